// ===== sv/mclr_pkg.sv =====
// ----------------------------------------------------------------------------
// mclr_pkg
// Shared types and constants of the multi-channel load regulator.
// ----------------------------------------------------------------------------
package mclr_pkg;

    localparam int CHANNELS   = 128;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int BUSY_W     = 48;
    localparam int ELAP_W     = 20;
    localparam int LOAD_W     = 16;
    localparam int DRIVE_W    = 27;
    localparam int INTEG_W    = 25;
    localparam int ERR_W      = 18;
    localparam int GAIN_W     = 20;
    localparam int LIMIT_W    = 24;
    localparam int TARGET_W   = 15;
    localparam int MULB_W     = 26;
    localparam int PROD_W     = GAIN_W + 1 + MULB_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_W      = BUSY_W + 15;
    localparam int REM_W      = ELAP_W + LOAD_W;
    localparam logic [LOAD_W-1:0] LOAD_SAT = '1;

    // register indexes on the configuration port
    localparam logic [2:0] REG_TARGET   = 3'd0;
    localparam logic [2:0] REG_GAIN_P   = 3'd1;
    localparam logic [2:0] REG_GAIN_I   = 3'd2;
    localparam logic [2:0] REG_GAIN_D   = 3'd3;
    localparam logic [2:0] REG_INT_LIM  = 3'd4;
    localparam logic [2:0] REG_DRV_MAX  = 3'd5;
    localparam logic [2:0] REG_DRV_MIN  = 3'd6;

    // multiplier operand select
    localparam logic [1:0] MUL_P = 2'd0;
    localparam logic [1:0] MUL_I = 2'd1;
    localparam logic [1:0] MUL_D = 2'd2;

    typedef struct packed {
        logic [TARGET_W-1:0] target_load;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [LIMIT_W-1:0]  integral_limit;
        logic [DRIVE_W-1:0]  drive_max;
        logic [DRIVE_W-1:0]  drive_min;
    } cfg_t;

    // one channel's state row
    typedef struct packed {
        logic [BUSY_W-1:0]         last_busy;
        logic [LOAD_W-1:0]         meas;
        logic signed [INTEG_W-1:0] integ;
        logic signed [ERR_W-1:0]   lerr;
        logic [DRIVE_W-1:0]        ldrive;
        logic [DRIVE_W-1:0]        limit;
    } row_t;

    typedef struct packed {
        logic       load_in;
        logic       mem_rd;
        logic       delta;
        logic       scale;
        logic       div_init;
        logic       div_step;
        logic       err;
        logic       integ;
        logic       mul;
        logic [1:0] mul_sel;
        logic       acc_clr;
        logic       acc;
        logic       drive;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== sv/mclr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mclr_ctrl
// Sequencer: steps one item through read, divide, PID and write-back.
// ----------------------------------------------------------------------------
module mclr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mclr_pkg::status_t status,
    output mclr_pkg::cmd_t    cmd
);
    import mclr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_DELTA = 4'd2;
    localparam logic [3:0] S_SCALE = 4'd3;
    localparam logic [3:0] S_DINIT = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_ERR   = 4'd6;
    localparam logic [3:0] S_INTEG = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_ACC   = 4'd9;
    localparam logic [3:0] S_DRIVE = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    // state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                cmd.mem_rd  = s_tvalid;
                if (s_tvalid) state_next = S_READ;
            end
            S_READ:  state_next = S_DELTA;
            S_DELTA: begin
                cmd.delta  = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) state_next = S_ERR;
            end
            S_ERR: begin
                cmd.err    = 1'b1;
                state_next = S_INTEG;
            end
            S_INTEG: begin
                cmd.integ  = 1'b1;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = cnt_reg[1:0];
                cmd.acc     = 1'b1;
                cmd.acc_clr = (cnt_reg[1:0] == MUL_P);
                cnt_next    = cnt_reg + 4'd1;
                if (cnt_reg[1:0] == MUL_D) state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = S_DRIVE;
            end
            S_DRIVE: begin
                cmd.drive  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== sv/mclr_dp.sv =====
// ----------------------------------------------------------------------------
// mclr_dp
// Datapath: channel state memory, load divider, shared PID multiplier,
// output clamp and result register.
// ----------------------------------------------------------------------------
module mclr_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mclr_pkg::cfg_t                cfg,
    input  mclr_pkg::cmd_t                cmd,
    output mclr_pkg::status_t             status,
    input  logic [mclr_pkg::CH_W-1:0]     in_channel,
    input  logic [mclr_pkg::BUSY_W-1:0]   in_busy,
    input  logic [mclr_pkg::ELAP_W-1:0]   in_elapsed,
    input  logic                          in_slipped,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mclr_pkg::CH_W-1:0]     out_channel,
    output logic [mclr_pkg::LOAD_W-1:0]   out_load,
    output logic [mclr_pkg::DRIVE_W-1:0]  out_limit,
    output logic                          out_updated
);
    import mclr_pkg::*;

    // input holding registers
    logic [CH_W-1:0]   ch_reg;
    logic [BUSY_W-1:0] busy_reg;
    logic [ELAP_W-1:0] elap_reg;
    logic              slip_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ch_reg   <= in_channel;
            busy_reg <= in_busy;
            elap_reg <= in_elapsed;
            slip_reg <= in_slipped;
        end
    end

    // channel state memory; an unwritten row reads as zero
    row_t             mem [CHANNELS];
    row_t             rdata_reg;
    logic [CHANNELS-1:0] valid_reg;
    logic             rvalid_reg;
    row_t             row;
    row_t             wrow;

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) rdata_reg <= mem[in_channel];
        if (cmd.commit) mem[ch_reg] <= wrow;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (cmd.mem_rd) rvalid_reg <= valid_reg[in_channel];
            if (cmd.commit) valid_reg[ch_reg] <= 1'b1;
        end
    end

    assign row = rvalid_reg ? rdata_reg : '0;

    // measured load: delta*25600 / elapsed, restoring divide, one bit a cycle
    logic [BUSY_W-1:0] delta_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  num_full;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  dvs_reg;
    logic [LOAD_W-1:0] quo_reg;
    logic              sat_reg;
    logic              zero_reg;
    logic [REM_W:0]    trial;

    assign num_full = num_reg << 8;
    assign trial    = {1'b0, rem_reg} - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (cmd.delta) delta_reg <= busy_reg - row.last_busy;
        // times 100 by shifts; the remaining 256 is a shift later
        if (cmd.scale) num_reg <= {9'b0, delta_reg, 6'b0}
                                + {10'b0, delta_reg, 5'b0}
                                + {13'b0, delta_reg, 2'b0};
        if (cmd.div_init) begin
            zero_reg <= (delta_reg == '0);
            sat_reg  <= (num_full >= {{(NUM_W-REM_W){1'b0}}, elap_reg, 16'b0});
            rem_reg  <= num_full[REM_W-1:0];
            dvs_reg  <= {1'b0, elap_reg, 15'b0};
            quo_reg  <= '0;
        end else if (cmd.div_step) begin
            if (!trial[REM_W]) rem_reg <= trial[REM_W-1:0];
            quo_reg <= {quo_reg[LOAD_W-2:0], ~trial[REM_W]};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    // error, integral and difference terms
    logic [LOAD_W-1:0]         meas_reg;
    logic [LOAD_W-1:0]         meas_c;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [INTEG_W-1:0] acc_reg;
    logic signed [ERR_W:0]     diff_reg;
    logic signed [INTEG_W:0]   isum;
    logic signed [INTEG_W:0]   ilim;
    logic signed [INTEG_W:0]   ilim_neg;

    always_comb begin
        priority if (slip_reg) meas_c = row.meas;
        else if (zero_reg)     meas_c = '0;
        else if (sat_reg)      meas_c = LOAD_SAT;
        else                   meas_c = quo_reg;
    end

    assign isum = {row.integ[INTEG_W-1], row.integ}
                + {{(INTEG_W+1-ERR_W){e_reg[ERR_W-1]}}, e_reg};
    assign ilim     = $signed({2'b0, cfg.integral_limit});
    assign ilim_neg = -ilim;

    always_ff @(posedge aclk) begin
        if (cmd.err) begin
            meas_reg <= meas_c;
            e_reg    <= $signed({3'b0, cfg.target_load}) - $signed({2'b0, meas_c});
        end
        if (cmd.integ) begin
            priority if (isum > ilim) acc_reg <= ilim[INTEG_W-1:0];
            else if (isum < ilim_neg) acc_reg <= ilim_neg[INTEG_W-1:0];
            else                      acc_reg <= isum[INTEG_W-1:0];
            diff_reg <= {row.lerr[ERR_W-1], row.lerr} - {e_reg[ERR_W-1], e_reg};
        end
    end

    // shared multiplier, product registered before accumulation
    logic [GAIN_W-1:0]        mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_P: begin
                mul_a = cfg.gain_p;
                mul_b = {{(MULB_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
            end
            MUL_I: begin
                mul_a = cfg.gain_i;
                mul_b = {acc_reg[INTEG_W-1], acc_reg};
            end
            MUL_D: begin
                mul_a = cfg.gain_d;
                mul_b = {{(MULB_W-ERR_W-1){diff_reg[ERR_W]}}, diff_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) prod_reg <= $signed({1'b0, mul_a}) * mul_b;
        if (cmd.acc) begin
            if (cmd.acc_clr) sum_reg <= '0;
            else sum_reg <= sum_reg + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // drive step: last drive plus rounded Q.8 sum
    logic signed [SUM_W-1:0] drive_reg;
    logic signed [SUM_W-1:0] step;
    logic [DRIVE_W-1:0]      drive_c;
    logic [DRIVE_W-1:0]      limit_c;

    assign step = (sum_reg + SUM_W'(128)) >>> 8;

    always_ff @(posedge aclk) begin
        if (cmd.drive)
            drive_reg <= $signed({{(SUM_W-DRIVE_W){1'b0}}, row.ldrive}) + step;
    end

    // upper clamp is tested first
    always_comb begin
        priority if (drive_reg > $signed({{(SUM_W-DRIVE_W){1'b0}}, cfg.drive_max}))
            drive_c = cfg.drive_max;
        else if (drive_reg < $signed({{(SUM_W-DRIVE_W){1'b0}}, cfg.drive_min}))
            drive_c = cfg.drive_min;
        else
            drive_c = drive_reg[DRIVE_W-1:0];
    end

    assign limit_c = slip_reg ? row.limit : drive_c;

    always_comb begin
        wrow.last_busy = busy_reg;
        wrow.meas      = meas_reg;
        wrow.integ     = acc_reg;
        wrow.lerr      = e_reg;
        wrow.ldrive    = drive_c;
        wrow.limit     = limit_c;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (cmd.commit) begin
            out_valid <= 1'b1;
        end else if (out_ready) begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_channel <= ch_reg;
            out_load    <= meas_reg;
            out_limit   <= limit_c;
            out_updated <= ~slip_reg;
        end
    end

    assign status.out_free = ~out_valid | out_ready;

endmodule

// ===== sv/multi_channel_pid_load_regulator_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_pid_load_regulator_core
// Per-channel load measurement and velocity-form PID regulator.
// ----------------------------------------------------------------------------
// One item at a time: a new input is taken only after the previous result has
// been committed, and the commit waits while the result register is still full.
// The 16-step load divider and the three passes of the shared PID multiplier
// make up most of each item's sequence. Reset (aresetn, synchronous) clears all channel state
// through per-channel valid bits at once and loads register defaults.
module multi_channel_pid_load_regulator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // channel[6:0], busy_time_us[54:7], elapsed_us[74:55]
    input  logic [0:0]  s_tuser,   // slipped
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // channel_out[6:0], measured_load[22:7], loop_limit[49:23]
    output logic [0:0]  m_tuser,   // updated
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mclr_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    logic [2:0] reg_idx;
    logic [CH_W-1:0]    out_channel;
    logic [LOAD_W-1:0]  out_load;
    logic [DRIVE_W-1:0] out_limit;
    logic               out_updated;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_load    <= '0;
            cfg_reg.gain_p         <= GAIN_W'(200000);
            cfg_reg.gain_i         <= GAIN_W'(500);
            cfg_reg.gain_d         <= GAIN_W'(2);
            cfg_reg.integral_limit <= LIMIT_W'(2560000);
            cfg_reg.drive_max      <= DRIVE_W'(100000000);
            cfg_reg.drive_min      <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_TARGET:  cfg_reg.target_load    <= pwdata[TARGET_W-1:0];
                REG_GAIN_P:  cfg_reg.gain_p         <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:  cfg_reg.gain_i         <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:  cfg_reg.gain_d         <= pwdata[GAIN_W-1:0];
                REG_INT_LIM: cfg_reg.integral_limit <= pwdata[LIMIT_W-1:0];
                REG_DRV_MAX: cfg_reg.drive_max      <= pwdata[DRIVE_W-1:0];
                REG_DRV_MIN: cfg_reg.drive_min      <= pwdata[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_TARGET:  prdata = {17'b0, cfg_reg.target_load};
            REG_GAIN_P:  prdata = {12'b0, cfg_reg.gain_p};
            REG_GAIN_I:  prdata = {12'b0, cfg_reg.gain_i};
            REG_GAIN_D:  prdata = {12'b0, cfg_reg.gain_d};
            REG_INT_LIM: prdata = {8'b0, cfg_reg.integral_limit};
            REG_DRV_MAX: prdata = {5'b0, cfg_reg.drive_max};
            REG_DRV_MIN: prdata = {5'b0, cfg_reg.drive_min};
            default:     prdata = '0;
        endcase
    end

    mclr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mclr_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .status      (status),
        .in_channel  (s_tdata[6:0]),
        .in_busy     (s_tdata[54:7]),
        .in_elapsed  (s_tdata[74:55]),
        .in_slipped  (s_tuser[0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_channel (out_channel),
        .out_load    (out_load),
        .out_limit   (out_limit),
        .out_updated (out_updated)
    );

    assign m_tdata = {6'b0, out_limit, out_load, out_channel};
    assign m_tuser = out_updated;

endmodule

// ===== tb/sv/multi_channel_pid_load_regulator_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_channel_pid_load_regulator_core_tb
// Drives load updates over the input stream under several register settings
// and checks every result transfer against a per-channel load/PID predictor or a fixed expectation.
// ----------------------------------------------------------------------------
module multi_channel_pid_load_regulator_core_tb;
    import mclr_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_ITEMS  = 500;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [BUSY_W-1:0] busy;
        logic [ELAP_W-1:0] elapsed;
        logic              slipped;
    } update_t;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [LOAD_W-1:0]  load;
        logic [DRIVE_W-1:0] limit;
        logic               updated;
    } regulation_t;

    typedef struct packed {
        update_t            upd;
        logic               fixed;
        logic [LOAD_W-1:0]  load;
        logic [DRIVE_W-1:0] limit;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;      // channel[6:0], busy_time_us[54:7], elapsed_us[74:55]
    logic [0:0]  s_tuser = '0;      // slipped
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // channel_out[6:0], measured_load[22:7], loop_limit[49:23]
    logic [0:0]  m_tuser;           // updated
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of registers and channel state
    cfg_t                      cfg;
    logic [BUSY_W-1:0]         last_busy [CHANNELS];
    logic [LOAD_W-1:0]         meas_load [CHANNELS];
    longint                    integ_acc [CHANNELS];
    longint                    last_err  [CHANNELS];
    logic [DRIVE_W-1:0]        last_drv  [CHANNELS];
    logic [DRIVE_W-1:0]        loop_lim  [CHANNELS];

    regulation_t expected_results[$];
    regulation_t fixed_result;
    logic        fixed_pending = 1'b0;
    int          errors = 0;
    int          idle_cycles = 0;
    stim_row_t   directed[10];

    // receiver stall pattern state
    int          mode_left = 0;
    int          mode = 0;

    multi_channel_pid_load_regulator_core i_dut (.*);

    always #HALF_PERIOD aclk = ~aclk;

    // compute one channel update and advance the predictor state
    function automatic regulation_t regulate(update_t u);
        regulation_t       r;
        logic [BUSY_W-1:0] delta;
        longint unsigned   m;
        longint            e, acc, lim, sum, drive;
        int                ch;
        ch = u.channel;
        delta = u.busy - last_busy[ch];
        last_busy[ch] = u.busy;
        if (!u.slipped) begin
            if (u.elapsed == 0) begin
                m = (delta != 0) ? 65535 : 0;
            end else begin
                m = (longint'(delta) * 25600) / longint'(u.elapsed);
                if (m > 65535) m = 65535;
            end
            meas_load[ch] = m[LOAD_W-1:0];
        end
        e = longint'(cfg.target_load) - longint'(meas_load[ch]);
        lim = longint'(cfg.integral_limit);
        acc = integ_acc[ch] + e;
        if (acc > lim) acc = lim;
        else if (acc < -lim) acc = -lim;
        integ_acc[ch] = acc;
        sum = longint'(cfg.gain_p) * e + longint'(cfg.gain_i) * acc
            + longint'(cfg.gain_d) * (last_err[ch] - e);
        last_err[ch] = e;
        // round half up, then floor via arithmetic shift
        drive = longint'(last_drv[ch]) + ((sum + 128) >>> 8);
        if (drive > longint'(cfg.drive_max)) drive = longint'(cfg.drive_max);
        else if (drive < longint'(cfg.drive_min)) drive = longint'(cfg.drive_min);
        last_drv[ch] = drive[DRIVE_W-1:0];
        if (!u.slipped) loop_lim[ch] = drive[DRIVE_W-1:0];
        r.channel = u.channel;
        r.load    = meas_load[ch];
        r.limit   = loop_lim[ch];
        r.updated = ~u.slipped;
        return r;
    endfunction

    // input transfer: predict and queue
    always @(posedge aclk) begin : input_monitor
        regulation_t r;
        if (aresetn && s_tvalid && s_tready) begin
            r = regulate(update_t'({s_tdata[6:0], s_tdata[54:7], s_tdata[74:55], s_tuser[0]}));
            expected_results.push_back(fixed_pending ? fixed_result : r);
        end
    end

    // result transfer: compare with oldest expectation
    always @(posedge aclk) begin : result_checker
        regulation_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[6:0], m_tdata[22:7], m_tdata[49:23], m_tuser[0]};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transfer %p", $realtime, got);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.channel !== exp_r.channel) begin
                    $display("%0t: channel exp %0d got %0d", $realtime, exp_r.channel, got.channel);
                    errors++;
                end
                if (got.load !== exp_r.load) begin
                    $display("%0t: load exp %0d got %0d", $realtime, exp_r.load, got.load);
                    errors++;
                end
                if (got.limit !== exp_r.limit) begin
                    $display("%0t: limit exp %0d got %0d", $realtime, exp_r.limit, got.limit);
                    errors++;
                end
                if (got.updated !== exp_r.updated) begin
                    $display("%0t: updated exp %0b got %0b", $realtime, exp_r.updated,
                             got.updated);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure: alternating modes, some fully ready
    always @(negedge aclk) begin : result_sink
        if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_TARGET:  cfg.target_load    = value[TARGET_W-1:0];
            REG_GAIN_P:  cfg.gain_p         = value[GAIN_W-1:0];
            REG_GAIN_I:  cfg.gain_i         = value[GAIN_W-1:0];
            REG_GAIN_D:  cfg.gain_d         = value[GAIN_W-1:0];
            REG_INT_LIM: cfg.integral_limit = value[LIMIT_W-1:0];
            REG_DRV_MAX: cfg.drive_max      = value[DRIVE_W-1:0];
            REG_DRV_MIN: cfg.drive_min      = value[DRIVE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(cfg_t c);
        write_reg(REG_TARGET,  32'(c.target_load));
        write_reg(REG_GAIN_P,  32'(c.gain_p));
        write_reg(REG_GAIN_I,  32'(c.gain_i));
        write_reg(REG_GAIN_D,  32'(c.gain_d));
        write_reg(REG_INT_LIM, 32'(c.integral_limit));
        write_reg(REG_DRV_MAX, 32'(c.drive_max));
        write_reg(REG_DRV_MIN, 32'(c.drive_min));
    endtask

    // drain outstanding results, then let the pipeline settle
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one input transfer; valid stays up into the next item unless a gap follows
    task automatic send_update(update_t u, logic fixed, regulation_t fr);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, u.elapsed, u.busy, u.channel};
        s_tuser  <= u.slipped;
        fixed_pending <= fixed;
        fixed_result  <= fr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if ($urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 30);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    function automatic update_t random_update();
        update_t u;
        int      pick;
        u.channel = ($urandom_range(0, 9) < 8) ? CH_W'($urandom_range(0, 7))
                                               : CH_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (pick < 85)      u.elapsed = ELAP_W'($urandom_range(1000, 20000));
        else if (pick < 90) u.elapsed = '0;
        else                u.elapsed = ELAP_W'($urandom);
        if ($urandom_range(0, 99) < 85)
            u.busy = last_busy[u.channel] + BUSY_W'($urandom_range(0, (u.elapsed * 11) / 10));
        else
            u.busy = BUSY_W'({$urandom, $urandom});
        u.slipped = ($urandom_range(0, 9) == 0);
        return u;
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) send_update(random_update(), 1'b0, '0);
    endtask

    initial begin : stimulus
        cfg_t c;
        cfg = '{target_load: 0, gain_p: 200000, gain_i: 500, gain_d: 2,
                integral_limit: 2560000, drive_max: 100000000, drive_min: 0};
        for (int k = 0; k < CHANNELS; k++) begin
            last_busy[k] = '0; meas_load[k] = '0; integ_acc[k] = 0;
            last_err[k] = 0;  last_drv[k] = '0;  loop_lim[k] = '0;
        end
        // directed rows; fixed expectations follow from reset defaults
        directed[0] = '{'{7'd0,   48'd0,              20'd1000,   1'b0}, 1'b1, 16'd0,     27'd0};
        directed[1] = '{'{7'd1,   48'hFFFF_FFFF_FFFF, 20'd1000,   1'b0}, 1'b1, 16'd65535, 27'd0};
        directed[2] = '{'{7'd2,   48'd123,            20'd1000,   1'b1}, 1'b1, 16'd0,     27'd0};
        directed[3] = '{'{7'd3,   48'd5,              20'd0,      1'b0}, 1'b1, 16'd65535, 27'd0};
        directed[4] = '{'{7'd4,   48'd0,              20'd0,      1'b0}, 1'b1, 16'd0,     27'd0};
        // busy time going backwards wraps
        directed[5] = '{'{7'd1,   48'd10,             20'd999999, 1'b0}, 1'b0, 16'd0,     27'd0};
        directed[6] = '{'{7'd127, 48'd500,            20'd1000,   1'b0}, 1'b0, 16'd0,     27'd0};
        directed[7] = '{'{7'd127, 48'd1000,           20'd1000,   1'b1}, 1'b0, 16'd0,     27'd0};
        directed[8] = '{'{7'd127, 48'd1800,           20'd1000,   1'b0}, 1'b0, 16'd0,     27'd0};
        directed[9] = '{'{7'd5,   48'h7FFF_FFFF_FFFF, 20'hFFFFF,  1'b0}, 1'b0, 16'd0,     27'd0};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_update(directed[i].upd, directed[i].fixed,
                        '{directed[i].upd.channel, directed[i].load, directed[i].limit,
                          ~directed[i].upd.slipped});
        wait_drained();

        // mid-range target, default gains
        write_reg(REG_TARGET, 32'd12800);
        random_phase(RANDOM_ITEMS / 5);
        wait_drained();

        // all registers but the lower clamp at their field maximum
        write_all('{target_load: '1, gain_p: '1, gain_i: '1, gain_d: '1,
                    integral_limit: '1, drive_max: '1, drive_min: '0});
        random_phase(RANDOM_ITEMS / 5);
        wait_drained();

        // lower clamp above upper clamp
        write_all('{target_load: 15'd25600, gain_p: 20'd1000, gain_i: 20'd50, gain_d: 20'd7,
                    integral_limit: 24'd100000, drive_max: 27'd5000, drive_min: 27'd90000});
        random_phase(RANDOM_ITEMS / 10);
        wait_drained();

        // everything zero
        write_all('0);
        random_phase(RANDOM_ITEMS / 10);
        wait_drained();

        // random settings
        repeat (4) begin
            c.target_load    = TARGET_W'($urandom);
            c.gain_p         = GAIN_W'($urandom);
            c.gain_i         = GAIN_W'($urandom);
            c.gain_d         = GAIN_W'($urandom);
            c.integral_limit = LIMIT_W'($urandom);
            c.drive_max      = DRIVE_W'($urandom);
            c.drive_min      = DRIVE_W'($urandom_range(0, 1000));
            write_all(c);
            random_phase(RANDOM_ITEMS / 10);
            wait_drained();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mclr_pkg.sv
sv/mclr_ctrl.sv
sv/mclr_dp.sv
sv/multi_channel_pid_load_regulator_core.sv
tb/sv/multi_channel_pid_load_regulator_core_tb.sv
